/* sv/joystick_deadman_twist_shaper_defines.svh */
// Assertion macros shared by the joystick deadman twist shaper RTL.
`ifndef JOYSTICK_DEADMAN_TWIST_SHAPER_DEFINES_SVH
`define JOYSTICK_DEADMAN_TWIST_SHAPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JDTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JDTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/jdts_pkg.sv */
// Types and constants of the joystick deadman twist shaper.
package jdts_pkg;

    // Field widths
    localparam int AXIS_W      = 16;
    localparam int AXIS_FIELDS = 8;
    localparam int AXIS_CNT_W  = 4;
    localparam int BTN_W       = 16;
    localparam int BTN_CNT_W   = 5;
    localparam int DM_W        = 4;
    localparam int DZ_W        = 15;
    localparam int CODE_W      = 4;
    localparam int SEL_W       = 24;
    localparam int SCALE_W     = 16;
    localparam int SCALES_W    = 48;
    localparam int NUM_OUT     = 6;

    // Arithmetic
    localparam int MAG_W     = 15;
    localparam int QUO_W     = 15;
    localparam int PROD_W    = 31;
    localparam int FRAC_BITS = 12;
    localparam logic [MAG_W-1:0] FULL_SCALE = 15'h7FFF;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_DEADMAN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_SEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_SCALES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_SCALES = 3'd4;

    // Register reset values
    localparam logic [DM_W-1:0]     RST_DEADMAN    = 4'd4;
    localparam logic [DZ_W-1:0]     RST_DEADZONE   = 15'd3277;
    localparam logic [SEL_W-1:0]    RST_AXIS_SEL   = 24'h3FF401;
    localparam logic [SCALES_W-1:0] RST_LIN_SCALES = 48'h1000_1000_1000;
    localparam logic [SCALES_W-1:0] RST_ANG_SCALES = 48'h0;

    // Command to the shared axis unit
    typedef struct packed {
        logic start;
        logic enable;
    } jdts_unit_cmd_t;

endpackage

/* sv/jdts_if.sv */
// Channel interfaces: joystick reports in, twist commands out, register writes.
interface jdts_joy_if import jdts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] axis_0;
    logic signed [AXIS_W-1:0] axis_1;
    logic signed [AXIS_W-1:0] axis_2;
    logic signed [AXIS_W-1:0] axis_3;
    logic signed [AXIS_W-1:0] axis_4;
    logic signed [AXIS_W-1:0] axis_5;
    logic signed [AXIS_W-1:0] axis_6;
    logic signed [AXIS_W-1:0] axis_7;
    logic [AXIS_CNT_W-1:0]    axis_count;
    logic [BTN_W-1:0]         button_mask;
    logic [BTN_CNT_W-1:0]     button_count;

    modport source (
        output valid, axis_0, axis_1, axis_2, axis_3, axis_4, axis_5, axis_6, axis_7,
        output axis_count, button_mask, button_count,
        input  ready
    );
    modport sink (
        input  valid, axis_0, axis_1, axis_2, axis_3, axis_4, axis_5, axis_6, axis_7,
        input  axis_count, button_mask, button_count,
        output ready
    );
endinterface

interface jdts_twist_if import jdts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] lin_x;
    logic signed [AXIS_W-1:0] lin_y;
    logic signed [AXIS_W-1:0] lin_z;
    logic signed [AXIS_W-1:0] ang_x;
    logic signed [AXIS_W-1:0] ang_y;
    logic signed [AXIS_W-1:0] ang_z;
    logic                     stop_marker;

    modport source (
        output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, stop_marker,
        input  ready
    );
    modport sink (
        input  valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, stop_marker,
        output ready
    );
endinterface

interface jdts_cfg_if import jdts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/jdts_axis_unit.sv */
// Shared axis unit: deadzone, bit-serial rescale divide, bit-serial scale multiply.
module jdts_axis_unit import jdts_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  jdts_unit_cmd_t            cmd,
    input  logic signed [AXIS_W-1:0]  axis,
    input  logic [DZ_W-1:0]           deadzone,
    input  logic signed [SCALE_W-1:0] scale,
    output logic                      done,
    output logic signed [AXIS_W-1:0]  result
);

    typedef enum logic [2:0] {
        U_IDLE,
        U_CHK,
        U_NUM,
        U_DIV,
        U_MUL,
        U_RES
    } ustate_t;

    localparam int CNT_W = $clog2(QUO_W);
    localparam int HI_W  = PROD_W - FRAC_BITS;

    ustate_t                  state_reg;
    logic                     en_reg;
    logic                     sgn_reg;
    logic [MAG_W-1:0]         a_reg;
    logic [MAG_W-1:0]         diff_reg;
    logic [MAG_W-1:0]         den_reg;
    logic [MAG_W-1:0]         rem_reg;
    logic [MAG_W-1:0]         dvd_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [PROD_W-1:0]        mcand_reg;
    logic [SCALE_W-1:0]       mplier_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic                     done_reg;
    logic signed [AXIS_W-1:0] result_reg;

    logic [AXIS_W-1:0]        axis_neg;
    logic [MAG_W-1:0]         a_next;
    logic [MAG_W:0]           dz_diff;
    logic                     in_dead;
    logic [2*MAG_W-1:0]       num;
    logic [MAG_W+1:0]         trial;
    logic                     qbit;
    logic [MAG_W-1:0]         rem_next;
    logic [QUO_W-1:0]         quo_next;
    logic [SCALE_W-1:0]       scale_u;
    logic [SCALE_W-1:0]       scale_mag;
    logic [PROD_W-1:0]        acc_sum;
    logic [HI_W-1:0]          prod_hi;
    logic [MAG_W-1:0]         mag_sat;
    logic [AXIS_W-1:0]        res_val;
    logic                     done_next;

    always_comb
    begin
        // Magnitude with the most negative code folded onto full scale
        axis_neg = AXIS_W'(-axis);
        if (!axis[AXIS_W-1])
        begin
            a_next = axis[MAG_W-1:0];
        end
        else if (axis_neg[AXIS_W-1])
        begin
            a_next = FULL_SCALE;
        end
        else
        begin
            a_next = axis_neg[MAG_W-1:0];
        end

        dz_diff = {1'b0, a_reg} - {1'b0, deadzone};
        in_dead = dz_diff[MAG_W] || (dz_diff == '0);

        // (a - dz) * 32767 as a shift and subtract
        num = {diff_reg, {MAG_W{1'b0}}} - {{MAG_W{1'b0}}, diff_reg};

        // One restoring divide step
        trial    = {1'b0, rem_reg, dvd_reg[MAG_W-1]} - {2'b00, den_reg};
        qbit     = !trial[MAG_W+1];
        rem_next = qbit ? trial[MAG_W-1:0] : {rem_reg[MAG_W-2:0], dvd_reg[MAG_W-1]};
        quo_next = {quo_reg[QUO_W-2:0], qbit};

        scale_u   = scale;
        scale_mag = scale_u[SCALE_W-1] ? (~scale_u + SCALE_W'(1)) : scale_u;

        acc_sum = acc_reg + mcand_reg;

        // Drop the fraction, saturate, restore the sign
        prod_hi = acc_reg[PROD_W-1:FRAC_BITS];
        mag_sat = (prod_hi > HI_W'(FULL_SCALE)) ? FULL_SCALE : prod_hi[MAG_W-1:0];
        res_val = sgn_reg ? AXIS_W'(-{1'b0, mag_sat}) : {1'b0, mag_sat};

        // Finish on a zero output or once the product is ready
        done_next = ((state_reg == U_CHK) && (!en_reg || in_dead)) || (state_reg == U_RES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
            en_reg     <= 1'b0;
            sgn_reg    <= 1'b0;
            a_reg      <= '0;
            diff_reg   <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            dvd_reg    <= '0;
            quo_reg    <= '0;
            cnt_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            done_reg <= done_next;
            case (state_reg)
                U_IDLE:
                begin
                    if (cmd.start)
                    begin
                        a_reg     <= a_next;
                        sgn_reg   <= axis[AXIS_W-1];
                        en_reg    <= cmd.enable;
                        state_reg <= U_CHK;
                    end
                end
                U_CHK:
                begin
                    if (!en_reg || in_dead)
                    begin
                        result_reg <= '0;
                        state_reg  <= U_IDLE;
                    end
                    else
                    begin
                        diff_reg  <= dz_diff[MAG_W-1:0];
                        den_reg   <= ~deadzone;
                        state_reg <= U_NUM;
                    end
                end
                U_NUM:
                begin
                    rem_reg    <= num[2*MAG_W-1:MAG_W];
                    dvd_reg    <= num[MAG_W-1:0];
                    cnt_reg    <= '0;
                    mplier_reg <= scale_mag;
                    sgn_reg    <= sgn_reg ^ scale_u[SCALE_W-1];
                    state_reg  <= U_DIV;
                end
                U_DIV:
                begin
                    rem_reg <= rem_next;
                    dvd_reg <= {dvd_reg[MAG_W-2:0], 1'b0};
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(QUO_W - 1))
                    begin
                        mcand_reg <= PROD_W'(quo_next);
                        acc_reg   <= '0;
                        state_reg <= U_MUL;
                    end
                end
                U_MUL:
                begin
                    // Advance one multiplier bit; stop once no set bits remain
                    if (mplier_reg == '0)
                    begin
                        state_reg <= U_RES;
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= acc_sum;
                        end
                        mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[SCALE_W-1:1]};
                    end
                end
                U_RES:
                begin
                    result_reg <= res_val;
                    state_reg  <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* sv/joystick_deadman_twist_shaper.sv */
// Top level of the joystick deadman twist shaper.
//
// Turns one joystick report into one twist command. A report transfers on joy when
// valid and ready are both high; ready is high whenever no report is being shaped.
// If the configured deadman button is not pressed (a button number at or beyond the
// report's button count counts as released), the report yields nothing, except the
// first report after a held period, which yields one all-zero item with stop_marker
// set. While the button is held, each of the six outputs takes the axis chosen by
// axis_select (codes 8-15, or at or beyond the axis count, give 0), clamps it to
// +/-32767, zeroes it inside the deadzone, rescales the rest to full scale as
// (|x|-dz)*32767/(32767-dz), restores the sign, multiplies by its signed Q4.12 scale
// with truncation toward zero and saturates to +/-32767. The six outputs are
// computed one after another by a single axis unit that holds a bit-serial restoring
// divider (15 steps) and a shift-add multiplier (one step per significant bit of the
// scale magnitude, at most 16). An output that is disabled or in the deadzone skips
// both and yields 0. The result sits in an output register, so the next report
// transfers while the last command still waits on twist. Registers are written
// through cfg, index 0 deadman button, 1 deadzone, 2 axis select, 3 linear scales,
// 4 angular scales; write them only while the block is idle.
`include "joystick_deadman_twist_shaper_defines.svh"

module joystick_deadman_twist_shaper import jdts_pkg::*; #(
    parameter int NUM_AXES    = 8,
    parameter int NUM_BUTTONS = 16
) (
    input logic           clk,
    input logic           rst_n,
    jdts_joy_if.sink      joy,
    jdts_twist_if.source  twist,
    jdts_cfg_if.sink      cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_EMIT
    } state_t;

    localparam int AXIS_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int K_W        = $clog2(NUM_OUT);
    localparam logic [K_W-1:0]        K_LAST     = K_W'(NUM_OUT - 1);
    localparam logic [AXIS_CNT_W-1:0] AXIS_LIMIT = AXIS_CNT_W'(NUM_AXES);
    localparam logic [BTN_CNT_W-1:0]  BTN_LIMIT  = BTN_CNT_W'(NUM_BUTTONS);

    // Configuration registers
    logic [DM_W-1:0]          deadman_reg;
    logic [DZ_W-1:0]          deadzone_reg;
    logic [SEL_W-1:0]         axis_sel_reg;
    logic [SCALES_W-1:0]      lin_scales_reg;
    logic [SCALES_W-1:0]      ang_scales_reg;

    // Sequencer and output register
    state_t                   state_reg;
    logic [K_W-1:0]           k_reg;
    logic                     was_en_reg;
    logic                     stop_reg;
    logic                     out_valid_reg;
    logic                     out_stop_reg;
    logic signed [AXIS_W-1:0] out_res_reg [NUM_OUT];

    // Captured report and results in flight
    logic signed [AXIS_W-1:0] axis_reg [NUM_AXES];
    logic [AXIS_CNT_W-1:0]    naxes_reg;
    logic signed [AXIS_W-1:0] res_reg [NUM_OUT];

    logic signed [AXIS_W-1:0] in_axes [AXIS_FIELDS];
    logic                     joy_xfer;
    logic                     held;
    logic [AXIS_CNT_W-1:0]    naxes_in;
    logic [CODE_W-1:0]        code;
    logic                     code_ok;
    logic signed [AXIS_W-1:0] axis_pick;
    logic signed [SCALE_W-1:0] scale_pick;
    logic                     out_load;

    jdts_unit_cmd_t           unit_cmd;
    logic                     unit_done;
    logic signed [AXIS_W-1:0] unit_result;

    assign in_axes[0] = joy.axis_0;
    assign in_axes[1] = joy.axis_1;
    assign in_axes[2] = joy.axis_2;
    assign in_axes[3] = joy.axis_3;
    assign in_axes[4] = joy.axis_4;
    assign in_axes[5] = joy.axis_5;
    assign in_axes[6] = joy.axis_6;
    assign in_axes[7] = joy.axis_7;

    assign joy.ready = (state_reg == S_IDLE);
    assign joy_xfer  = joy.valid && joy.ready;

    // Deadman: in range of both the report's count and the button limit, and pressed
    assign held = ({1'b0, deadman_reg} < joy.button_count)
               && ({1'b0, deadman_reg} < BTN_LIMIT)
               && joy.button_mask[deadman_reg];

    assign naxes_in = (joy.axis_count > AXIS_LIMIT) ? AXIS_LIMIT : joy.axis_count;

    // Select the axis code and scale for the output now in progress
    always_comb
    begin
        code      = axis_sel_reg[int'(k_reg) * CODE_W +: CODE_W];
        code_ok   = !code[CODE_W-1] && (code < naxes_reg);
        axis_pick = axis_reg[code[AXIS_IDX_W-1:0]];
        case (k_reg)
            3'd0:    scale_pick = lin_scales_reg[SCALE_W-1:0];
            3'd1:    scale_pick = lin_scales_reg[2*SCALE_W-1:SCALE_W];
            3'd2:    scale_pick = lin_scales_reg[3*SCALE_W-1:2*SCALE_W];
            3'd3:    scale_pick = ang_scales_reg[SCALE_W-1:0];
            3'd4:    scale_pick = ang_scales_reg[2*SCALE_W-1:SCALE_W];
            default: scale_pick = ang_scales_reg[3*SCALE_W-1:2*SCALE_W];
        endcase
    end

    assign unit_cmd.start  = (state_reg == S_START);
    assign unit_cmd.enable = code_ok;

    jdts_axis_unit u_axis (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (unit_cmd),
        .axis     (axis_pick),
        .deadzone (deadzone_reg),
        .scale    (scale_pick),
        .done     (unit_done),
        .result   (unit_result)
    );

    // Register writes; always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadman_reg    <= RST_DEADMAN;
            deadzone_reg   <= RST_DEADZONE;
            axis_sel_reg   <= RST_AXIS_SEL;
            lin_scales_reg <= RST_LIN_SCALES;
            ang_scales_reg <= RST_ANG_SCALES;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_DEADMAN:    deadman_reg    <= cfg.data[DM_W-1:0];
                REG_DEADZONE:   deadzone_reg   <= cfg.data[DZ_W-1:0];
                REG_AXIS_SEL:   axis_sel_reg   <= cfg.data[SEL_W-1:0];
                REG_LIN_SCALES: lin_scales_reg <= cfg.data[SCALES_W-1:0];
                REG_ANG_SCALES: ang_scales_reg <= cfg.data[SCALES_W-1:0];
                default:        ;
            endcase
        end
    end

    // Capture the report on transfer; shift each finished output into the result line
    always_ff @(posedge clk)
    begin
        if (joy_xfer)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                axis_reg[i] <= in_axes[i];
            end
            naxes_reg <= naxes_in;
        end
        if (state_reg == S_WAIT && unit_done)
        begin
            for (int i = 0; i < NUM_OUT - 1; i++)
            begin
                res_reg[i] <= res_reg[i + 1];
            end
            res_reg[NUM_OUT-1] <= unit_result;
        end
    end

    // Load the output register once it is empty or being drained this cycle
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || twist.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            was_en_reg    <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_stop_reg  <= 1'b0;
            for (int i = 0; i < NUM_OUT; i++)
            begin
                out_res_reg[i] <= '0;
            end
        end
        else
        begin
            // Drop valid once the command transfers, unless a new one loads
            if (out_valid_reg && twist.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (joy_xfer)
                    begin
                        if (held)
                        begin
                            // Motion enabled: walk the six outputs
                            was_en_reg <= 1'b1;
                            stop_reg   <= 1'b0;
                            k_reg      <= '0;
                            state_reg  <= S_START;
                        end
                        else if (was_en_reg)
                        begin
                            // Release after a held period: one stop item
                            was_en_reg <= 1'b0;
                            stop_reg   <= 1'b1;
                            state_reg  <= S_EMIT;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (unit_done)
                    begin
                        if (k_reg == K_LAST)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            k_reg     <= k_reg + K_W'(1);
                            state_reg <= S_START;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        for (int i = 0; i < NUM_OUT; i++)
                        begin
                            out_res_reg[i] <= stop_reg ? '0 : res_reg[i];
                        end
                        out_stop_reg  <= stop_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign twist.valid       = out_valid_reg;
    assign twist.lin_x       = out_res_reg[0];
    assign twist.lin_y       = out_res_reg[1];
    assign twist.lin_z       = out_res_reg[2];
    assign twist.ang_x       = out_res_reg[3];
    assign twist.ang_y       = out_res_reg[4];
    assign twist.ang_z       = out_res_reg[5];
    assign twist.stop_marker = out_stop_reg;

    // Output index stays within the six outputs
    `JDTS_ASSERT_NOW(a_k_range, 1'b1, k_reg <= K_LAST, "output index out of range")
    // A finished output that is not the last starts the next one
    `JDTS_ASSERT_NEXT(a_k_advance,
        (state_reg == S_WAIT) && unit_done && (k_reg != K_LAST),
        state_reg == S_START, "sequencer did not advance to next output")
    // A stop item is only built after the held flag is dropped
    `JDTS_ASSERT_NOW(a_stop_clears, (state_reg == S_EMIT) && stop_reg, !was_en_reg,
        "stop item while still marked enabled")
    // A stop item carries zero motion
    `JDTS_ASSERT_NOW(a_stop_zero, twist.valid && twist.stop_marker,
        (twist.lin_x == '0) && (twist.lin_y == '0) && (twist.lin_z == '0)
        && (twist.ang_x == '0) && (twist.ang_y == '0) && (twist.ang_z == '0),
        "stop item with nonzero motion")

endmodule
